FILE: rtl/wtg_pkg.sv
// Wavetable tone generator: shared types, constants and the sine level table.
// No dependencies; used by wtg_divider and wavetable_tone_generator.
`default_nettype none

package wtg_pkg;

    // Field and register widths
    localparam int CLOCK_RATE_W  = 27;
    localparam int FREQ_W        = 16;
    localparam int PERIOD_W      = 24;
    localparam int BASE_ENTRIES  = 32;
    localparam int SLOT_W        = 5;
    localparam int RAW_LEVEL_W   = 4;

    // Defaults for the top-level parameters
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int LEVEL_BITS_DEF  = 4;

    localparam logic [CLOCK_RATE_W-1:0] CLOCK_RATE_RESET = 27'd80000000;
    localparam logic [PERIOD_W-1:0]     PERIOD_MAX       = 24'hFFFFFF;

    // Request kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PLAY = 1'b1;

    // One period of a sine, 32 slots, 4-bit levels
    localparam logic [RAW_LEVEL_W-1:0] SINE_LEVELS [0:BASE_ENTRIES-1] = '{
        4'd8,  4'd9,  4'd11, 4'd12, 4'd13, 4'd14, 4'd14, 4'd15,
        4'd15, 4'd15, 4'd14, 4'd14, 4'd13, 4'd12, 4'd11, 4'd9,
        4'd8,  4'd7,  4'd5,  4'd4,  4'd3,  4'd2,  4'd2,  4'd1,
        4'd1,  4'd1,  4'd2,  4'd2,  4'd3,  4'd4,  4'd5,  4'd7
    };

    // Divider status towards the controller
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage : wtg_pkg

`default_nettype wire

FILE: rtl/wtg_divider.sv
// Restoring divider, one quotient bit per cycle, for the sample period.
// Depends on wtg_pkg (t_div_status; CLOCK_RATE_W and FREQ_W for the parameter defaults).
`default_nettype none

module wtg_divider #(
    parameter int DVD_W = wtg_pkg::CLOCK_RATE_W,
    parameter int DVS_W = wtg_pkg::FREQ_W + 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DVD_W-1:0]     i_dividend,
    input  wire logic [DVS_W-1:0]     i_divisor,
    output wtg_pkg::t_div_status      o_status,
    output logic      [DVD_W-1:0]     o_quotient
);

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DVS_W-1:0]   r_rem, n_rem;
    logic [DVS_W-1:0]   r_div, n_div;
    logic [DVD_W-1:0]   r_quo, n_quo;

    logic [DVS_W:0]     rem_sh;
    logic [DVS_W:0]     diff;

    // One trial subtraction per cycle
    always_comb begin
        rem_sh  = {r_rem, r_quo[DVD_W-1]};
        diff    = rem_sh - {1'b0, r_div};
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_div   = r_div;
        n_quo   = r_quo;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_div   = i_divisor;
                    n_quo   = i_dividend;
                end
            end
            S_RUN: begin
                if (!diff[DVS_W]) begin
                    n_rem = diff[DVS_W-1:0];
                    n_quo = {r_quo[DVD_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[DVS_W-1:0];
                    n_quo = {r_quo[DVD_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_status.busy = (r_state != S_IDLE);
    assign o_status.done = (r_state == S_DONE);
    assign o_quotient    = r_quo;

    // Checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("divider started while busy");

    a_run_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cnt == LAST_STEP) |=> (r_state == S_DONE))
        else $error("divider missed its last step");

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("divider done held for more than one cycle");

endmodule : wtg_divider

`default_nettype wire

FILE: rtl/wavetable_tone_generator.sv
// A tick or a silencing play request gives its registered result in the cycle after acceptance.
// A play request with a nonzero frequency keeps the block busy until the period divider
// is done; the divider resolves one quotient bit per cycle over the 27-bit clock rate.
// One tick per cycle while the divider is idle; ready also follows the output side (one result register).
// Reset (i_rst_n, synchronous, active low): silent, level 0, position 0, clock rate 80000000.
// Holds the countdown timer, wave position and level; uses wtg_divider and wtg_pkg.
`default_nettype none

module wavetable_tone_generator #(
    parameter int TABLE_DEPTH = wtg_pkg::TABLE_DEPTH_DEF,
    parameter int LEVEL_BITS  = wtg_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [wtg_pkg::CLOCK_RATE_W-1:0]  i_cfg_data,
    // request channel
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_operation,
    input  wire logic [wtg_pkg::FREQ_W-1:0]        i_tone_frequency,
    // result channel
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic      [LEVEL_BITS-1:0]             o_dac_level,
    output logic                                   o_sample_strobe,
    output logic                                   o_playing
);

    localparam int PW     = $clog2(TABLE_DEPTH);
    localparam int SPW    = PW + wtg_pkg::SLOT_W;
    localparam int DVS_W  = wtg_pkg::FREQ_W + $clog2(TABLE_DEPTH + 1);
    localparam int DVD_W  = wtg_pkg::CLOCK_RATE_W;
    localparam int PERW   = wtg_pkg::PERIOD_W;
    localparam int LWW    = wtg_pkg::RAW_LEVEL_W + LEVEL_BITS;
    localparam logic [PW-1:0] POS_LAST = PW'(TABLE_DEPTH - 1);

    // Reciprocal of the table depth, exact over every position
    localparam int RCP_K  = SPW + PW;
    localparam int RCP_W  = SPW + 2;
    localparam int PRD_W  = SPW + RCP_W;
    localparam logic [RCP_W-1:0] SLOT_RCP =
        RCP_W'(((longint'(1) << RCP_K) + longint'(TABLE_DEPTH) - 1) / longint'(TABLE_DEPTH));

    // Registers
    logic [DVD_W-1:0]       r_clock_rate;
    logic [PERW-1:0]        r_count, n_count;
    logic [PERW-1:0]        r_period, n_period;
    logic [PW-1:0]          r_pos, n_pos;
    logic                   r_tone_en, n_tone_en;
    logic [LEVEL_BITS-1:0]  r_level, n_level;
    logic                   r_strobe, n_strobe;
    logic                   r_out_valid, n_out_valid;

    // Divider hookup
    wtg_pkg::t_div_status   div_st;
    logic                   div_start;
    logic [DVS_W-1:0]       div_divisor;
    logic [DVD_W-1:0]       div_quo;
    logic [PERW-1:0]        period_sat;

    // Wave lookup
    logic [PRD_W-1:0]       slot_prod;
    logic [SPW-1:0]         slot_full;
    logic [wtg_pkg::SLOT_W-1:0] slot;
    logic [wtg_pkg::RAW_LEVEL_W-1:0] raw_level;
    logic [LWW-1:0]         level_wide;
    logic [LEVEL_BITS-1:0]  next_sample;

    logic                   in_acc;
    logic                   out_acc;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = r_out_valid && i_ready;
    assign o_ready = !div_st.busy && (!r_out_valid || i_ready);

    assign div_divisor = DVS_W'(i_tone_frequency) * DVS_W'(TABLE_DEPTH);

    wtg_divider #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_clock_rate),
        .i_divisor  (div_divisor),
        .o_status   (div_st),
        .o_quotient (div_quo)
    );

    // Period clamp: at least one tick, at most the timer range
    always_comb begin
        if (div_quo == '0) begin
            period_sat = PERW'(1);
        end else if (div_quo[DVD_W-1:PERW] != '0) begin
            period_sat = wtg_pkg::PERIOD_MAX;
        end else begin
            period_sat = div_quo[PERW-1:0];
        end
    end

    // Table slot for the current position (scaled by the depth reciprocal), scaled level
    always_comb begin
        slot_prod = PRD_W'({r_pos, {wtg_pkg::SLOT_W{1'b0}}}) * PRD_W'(SLOT_RCP);
        slot_full = SPW'(slot_prod >> RCP_K);
        if (slot_full >= SPW'(wtg_pkg::BASE_ENTRIES)) begin
            slot = wtg_pkg::SLOT_W'(wtg_pkg::BASE_ENTRIES - 1);
        end else begin
            slot = slot_full[wtg_pkg::SLOT_W-1:0];
        end
        raw_level   = wtg_pkg::SINE_LEVELS[slot];
        level_wide  = {raw_level, {LEVEL_BITS{1'b0}}} >> wtg_pkg::RAW_LEVEL_W;
        next_sample = level_wide[LEVEL_BITS-1:0];
    end

    // Request handling
    always_comb begin
        n_count     = r_count;
        n_period    = r_period;
        n_pos       = r_pos;
        n_tone_en   = r_tone_en;
        n_level     = r_level;
        n_strobe    = r_strobe;
        n_out_valid = r_out_valid;
        div_start   = 1'b0;

        if (out_acc) begin
            n_out_valid = 1'b0;
        end

        if (div_st.done) begin
            // new tone: restart the countdown at the new period
            n_period    = period_sat;
            n_count     = period_sat;
            n_tone_en   = 1'b1;
            n_strobe    = 1'b0;
            n_out_valid = 1'b1;
        end else if (in_acc) begin
            case (i_operation)
                wtg_pkg::OP_PLAY: begin
                    if (i_tone_frequency == '0) begin
                        n_level     = '0;
                        n_tone_en   = 1'b0;
                        n_count     = '0;
                        n_strobe    = 1'b1;
                        n_out_valid = 1'b1;
                    end else begin
                        div_start   = 1'b1;
                    end
                end
                wtg_pkg::OP_TICK: begin
                    n_strobe    = 1'b0;
                    n_out_valid = 1'b1;
                    if (r_tone_en) begin
                        if (r_count <= PERW'(1)) begin
                            n_count  = r_period;
                            n_level  = next_sample;
                            n_pos    = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
                            n_strobe = 1'b1;
                        end else begin
                            n_count  = r_count - 1'b1;
                        end
                    end
                end
                default: begin
                    n_out_valid = r_out_valid;
                end
            endcase
        end
    end

    // Control and tone state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_rate <= wtg_pkg::CLOCK_RATE_RESET;
            r_count      <= '0;
            r_period     <= '0;
            r_pos        <= '0;
            r_tone_en    <= 1'b0;
            r_level      <= '0;
            r_strobe     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_clock_rate <= i_cfg_data;
            end
            r_count     <= n_count;
            r_period    <= n_period;
            r_pos       <= n_pos;
            r_tone_en   <= n_tone_en;
            r_level     <= n_level;
            r_strobe    <= n_strobe;
            r_out_valid <= n_out_valid;
        end
    end

    // The level and tone flag come straight from their registers; a new tone shows once the division is done
    assign o_valid         = r_out_valid;
    assign o_dac_level     = r_level;
    assign o_sample_strobe = r_strobe;
    assign o_playing       = r_tone_en;

    // Checks
    a_period_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tone_en |-> (r_period != '0))
        else $error("tone enabled with a zero period");

    a_silence_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sample_strobe && !o_playing) |-> (o_dac_level == '0))
        else $error("silencing strobe with a nonzero level");

    a_play_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation == wtg_pkg::OP_PLAY && i_tone_frequency != '0)
        |=> !o_ready)
        else $error("accepted a request during the period division");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("table position out of range");

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> !r_out_valid)
        else $error("period result would overwrite a pending result");

endmodule : wavetable_tone_generator

`default_nettype wire
